### src/adjg_pkg.sv
// Shared types and constants for the adjacency list graph store.
package adjg_pkg;

   localparam int DefMaxVertices = 16;
   localparam int DefNodePool    = 64;
   localparam int MaxResults     = 64;
   localparam int VertexWidth    = 4;

   typedef enum logic [1:0] {
      KIND_ADD       = 2'd0,
      KIND_REMOVE    = 2'd1,
      KIND_EXISTS    = 2'd2,
      KIND_NEIGHBORS = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_FULL    = 2'd2
   } status_type;

   localparam logic CSR_UNDIRECTED   = 1'b0;
   localparam logic CSR_NUM_VERTICES = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD1,
      ST_ADD2,
      ST_WHEAD,
      ST_WNODE,
      ST_UNLINK,
      ST_LHEAD,
      ST_LNODE
   } state_type;

endpackage

### src/adjg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module adjg_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### src/adjacency_list_graph_store.sv
// Top level of the adjacency list graph store.
//
//   channel   handshake              payload
//   request   start / busy           req_kind, req_vertex_a, req_vertex_b
//   result    rsp_strobe (1 cycle)   rsp_status, rsp_edge_found, rsp_neighbor,
//                                    rsp_neighbor_valid, rsp_last
//   csr       csr_we                 csr_index, csr_wdata
//
// One item at a time. Invalid and pool-full items are answered from idle.
// Add writes a list entry (plus a mirror entry when undirected). Exists and
// remove walk a list through the node RAM read port; remove unlinks a found
// node and, when undirected, walks a second list. Neighbors streams up to 64 entries.
// Reset is immediate: list heads use valid bits, untouched pool nodes are
// tracked with a fill count. Results cannot be stalled.
module adjacency_list_graph_store #(
   parameter int MAX_VERTICES = adjg_pkg::DefMaxVertices,
   parameter int NODE_POOL    = adjg_pkg::DefNodePool
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_kind,
   input  logic [adjg_pkg::VertexWidth-1:0] req_vertex_a,
   input  logic [adjg_pkg::VertexWidth-1:0] req_vertex_b,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_edge_found,
   output logic [adjg_pkg::VertexWidth-1:0] rsp_neighbor,
   output logic                         rsp_neighbor_valid,
   output logic                         rsp_last,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [4:0]                   csr_wdata
);
   import adjg_pkg::*;

   localparam int NW  = $clog2(NODE_POOL + 1);
   localparam int NAW = $clog2(NODE_POOL);
   localparam int HAW = $clog2(MAX_VERTICES);
   localparam int VW  = VertexWidth;
   localparam int DW  = NW + VW;
   localparam int KW  = $clog2(MaxResults);
   localparam logic [NW-1:0] NIL = NW'(NODE_POOL);

   // configuration
   logic          undir_ff, undir_in;
   logic [4:0]    nvert_ff, nvert_in;

   // control
   state_type     state_ff, state_in;
   logic [1:0]    kind_ff, kind_in;
   logic [VW-1:0] a_ff, a_in, b_ff, b_in;
   logic [VW-1:0] list_ff, list_in, target_ff, target_in;
   logic          pass2_ff, pass2_in;
   logic [NW-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [VW-1:0] prev_vtx_ff, prev_vtx_in;
   logic          fwd_ff, fwd_in;
   logic [NW-1:0] fwd_node_ff, fwd_node_in;
   logic [KW-1:0] k_ff, k_in;
   logic [NW-1:0] free_head_ff, free_head_in;
   logic [NW-1:0] free_cnt_ff, free_cnt_in;
   logic [NW-1:0] fill_ff, fill_in;
   logic [MAX_VERTICES-1:0] hvalid_ff, hvalid_in;
   logic [HAW-1:0] hr_addr_ff, hr_addr_in;

   // result
   logic          strobe_ff, strobe_in;
   logic [1:0]    status_ff, status_in;
   logic          found_o_ff, found_o_in;
   logic [VW-1:0] nb_ff, nb_in;
   logic          nbv_ff, nbv_in;
   logic          last_ff, last_in;

   // memories
   logic           h_we;
   logic [HAW-1:0] h_waddr, h_raddr;
   logic [NW-1:0]  h_wdata, h_rdata;
   logic           n_we;
   logic [NAW-1:0] n_waddr, n_raddr;
   logic [DW-1:0]  n_wdata, n_rdata;

   adjg_ram #(.Width(NW), .Depth(MAX_VERTICES)) u_head (
      .clock(clock), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
      .raddr(h_raddr), .rdata(h_rdata)
   );

   adjg_ram #(.Width(DW), .Depth(NODE_POOL)) u_node (
      .clock(clock), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
      .raddr(n_raddr), .rdata(n_rdata)
   );

   logic [NW-1:0] hval;
   logic [VW-1:0] rd_vtx;
   logic [NW-1:0] rd_link;
   logic          va_ok, vb_ok;
   logic [NW-1:0] pop_nd, pop_next;
   logic [NW-1:0] push_head;

   assign hval    = hvalid_ff[hr_addr_ff] ? h_rdata : NIL;
   assign rd_vtx  = n_rdata[DW-1:NW];
   assign rd_link = n_rdata[NW-1:0];
   assign va_ok   = (32'(req_vertex_a) < 32'(nvert_ff)) && (32'(req_vertex_a) < MAX_VERTICES);
   assign vb_ok   = (32'(req_vertex_b) < 32'(nvert_ff)) && (32'(req_vertex_b) < MAX_VERTICES);
   // untouched pool nodes chain to the next index
   assign pop_nd   = free_head_ff;
   assign pop_next = (pop_nd == fill_ff) ? pop_nd + NW'(1) : rd_link;

   always_ff @(posedge clock) begin
      if (reset) begin
         undir_ff     <= 1'b1;
         nvert_ff     <= 5'd16;
         state_ff     <= ST_IDLE;
         free_head_ff <= '0;
         free_cnt_ff  <= NIL;
         fill_ff      <= '0;
         hvalid_ff    <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         undir_ff     <= undir_in;
         nvert_ff     <= nvert_in;
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         free_cnt_ff  <= free_cnt_in;
         fill_ff      <= fill_in;
         hvalid_ff    <= hvalid_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      list_ff     <= list_in;
      target_ff   <= target_in;
      pass2_ff    <= pass2_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      prev_vtx_ff <= prev_vtx_in;
      fwd_ff      <= fwd_in;
      fwd_node_ff <= fwd_node_in;
      k_ff        <= k_in;
      hr_addr_ff  <= hr_addr_in;
      status_ff   <= status_in;
      found_o_ff  <= found_o_in;
      nb_ff       <= nb_in;
      nbv_ff      <= nbv_in;
      last_ff     <= last_in;
   end

   always_comb begin
      undir_in     = undir_ff;
      nvert_in     = nvert_ff;
      state_in     = state_ff;
      kind_in      = kind_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      list_in      = list_ff;
      target_in    = target_ff;
      pass2_in     = pass2_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      prev_vtx_in  = prev_vtx_ff;
      fwd_in       = fwd_ff;
      fwd_node_in  = fwd_node_ff;
      k_in         = k_ff;
      free_head_in = free_head_ff;
      free_cnt_in  = free_cnt_ff;
      fill_in      = fill_ff;
      hvalid_in    = hvalid_ff;
      hr_addr_in   = hr_addr_ff;
      strobe_in    = 1'b0;
      status_in    = STAT_OK;
      found_o_in   = 1'b0;
      nb_in        = '0;
      nbv_in       = 1'b0;
      last_in      = 1'b1;
      h_we         = 1'b0;
      h_waddr      = HAW'(list_ff);
      h_wdata      = '0;
      h_raddr      = HAW'(req_vertex_a);
      n_we         = 1'b0;
      n_waddr      = NAW'(pop_nd);
      n_wdata      = '0;
      n_raddr      = NAW'(free_head_ff);
      push_head    = hval;

      if (csr_we) begin
         case (csr_index)
            CSR_UNDIRECTED:   undir_in = csr_wdata[0];
            CSR_NUM_VERTICES: nvert_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            hr_addr_in = HAW'(req_vertex_a);
            if (start) begin
               kind_in   = req_kind;
               a_in      = req_vertex_a;
               b_in      = req_vertex_b;
               list_in   = req_vertex_a;
               target_in = req_vertex_b;
               pass2_in  = 1'b0;
               if (!va_ok || (req_kind != KIND_NEIGHBORS && !vb_ok)) begin
                  strobe_in = 1'b1;
                  status_in = STAT_INVALID;
               end else begin
                  case (req_kind)
                     KIND_ADD: begin
                        if (free_cnt_ff < (undir_ff ? NW'(2) : NW'(1))) begin
                           strobe_in = 1'b1;
                           status_in = STAT_FULL;
                        end else begin
                           state_in = ST_ADD1;
                        end
                     end
                     KIND_NEIGHBORS: state_in = ST_LHEAD;
                     default:        state_in = ST_WHEAD;
                  endcase
               end
            end
         end

         ST_ADD1, ST_ADD2: begin
            if (state_ff == ST_ADD2 && fwd_ff) begin
               push_head = fwd_node_ff;
            end
            n_we    = 1'b1;
            n_waddr = NAW'(pop_nd);
            n_wdata = {target_ff, push_head};
            h_we    = 1'b1;
            h_waddr = HAW'(list_ff);
            h_wdata = pop_nd;
            hvalid_in[HAW'(list_ff)] = 1'b1;
            free_head_in = pop_next;
            free_cnt_in  = free_cnt_ff - NW'(1);
            if (pop_nd == fill_ff) begin
               fill_in = fill_ff + NW'(1);
            end
            if (state_ff == ST_ADD1 && undir_ff) begin
               // mirror entry: same list when a self loop
               fwd_in      = (a_ff == b_ff);
               fwd_node_in = pop_nd;
               list_in     = b_ff;
               target_in   = a_ff;
               h_raddr     = HAW'(b_ff);
               hr_addr_in  = HAW'(b_ff);
               n_raddr     = NAW'(pop_next);
               state_in    = ST_ADD2;
            end else begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         ST_WHEAD: begin
            prev_in = NIL;
            cur_in  = hval;
            if (hval == NIL) begin
               strobe_in  = 1'b1;
               found_o_in = pass2_ff;
               state_in   = ST_IDLE;
            end else begin
               n_raddr  = NAW'(hval);
               state_in = ST_WNODE;
            end
         end

         ST_WNODE: begin
            if (rd_vtx == target_ff) begin
               if (kind_ff == KIND_EXISTS) begin
                  strobe_in  = 1'b1;
                  found_o_in = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  if (prev_ff == NIL) begin
                     h_we    = 1'b1;
                     h_waddr = HAW'(list_ff);
                     h_wdata = rd_link;
                     hvalid_in[HAW'(list_ff)] = 1'b1;
                  end else begin
                     n_we    = 1'b1;
                     n_waddr = NAW'(prev_ff);
                     n_wdata = {prev_vtx_ff, rd_link};
                  end
                  state_in = ST_UNLINK;
               end
            end else if (rd_link == NIL) begin
               strobe_in  = 1'b1;
               found_o_in = pass2_ff;
               state_in   = ST_IDLE;
            end else begin
               prev_in     = cur_ff;
               prev_vtx_in = rd_vtx;
               cur_in      = rd_link;
               n_raddr     = NAW'(rd_link);
            end
         end

         ST_UNLINK: begin
            // freed node goes to the head of the free list
            n_we         = 1'b1;
            n_waddr      = NAW'(cur_ff);
            n_wdata      = {{VW{1'b0}}, free_head_ff};
            free_head_in = cur_ff;
            free_cnt_in  = free_cnt_ff + NW'(1);
            if (!pass2_ff && undir_ff) begin
               pass2_in   = 1'b1;
               list_in    = b_ff;
               target_in  = a_ff;
               h_raddr    = HAW'(b_ff);
               hr_addr_in = HAW'(b_ff);
               state_in   = ST_WHEAD;
            end else begin
               strobe_in  = 1'b1;
               found_o_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end

         ST_LHEAD: begin
            k_in = '0;
            if (hval == NIL) begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               n_raddr  = NAW'(hval);
               state_in = ST_LNODE;
            end
         end

         ST_LNODE: begin
            strobe_in = 1'b1;
            nb_in     = rd_vtx;
            nbv_in    = 1'b1;
            if (rd_link == NIL || k_ff == KW'(MaxResults - 1)) begin
               state_in = ST_IDLE;
            end else begin
               last_in = 1'b0;
               k_in    = k_ff + KW'(1);
               n_raddr = NAW'(rd_link);
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_edge_found     = found_o_ff;
   assign rsp_neighbor       = nb_ff;
   assign rsp_neighbor_valid = nbv_ff;
   assign rsp_last           = last_ff;
endmodule
